/* rtl/mau_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the modular arithmetic unit.
package mau_pkg;

  localparam int DATA_W = 31;
  localparam int EXP_W = 32;
  localparam int EXP_BITS = 32;
  localparam int CNT_W = $clog2(EXP_W);

  localparam logic [DATA_W-1:0] MOD_RESET = 31'd1000000007;
  localparam logic [EXP_W-1:0] EXP_MASK =
      (EXP_BITS >= EXP_W) ? {EXP_W{1'b1}} : EXP_W'((64'd1 << EXP_BITS) - 64'd1);

  localparam logic [2:0] OP_POWER = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_INV = 3'd5;

  typedef enum logic [2:0] {
    US_RED_A,
    US_RED_B,
    US_ACC_SQ,
    US_SQ_SQ,
    US_AR_SQ,
    US_AR_ACC
  } usel_t;

  typedef enum logic [1:0] {
    RS_ACC,
    RS_ADD,
    RS_SUB,
    RS_ZERO
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     unit_start;
    usel_t    unit_sel;
    logic     pow_init;
    logic     e_fermat;
    logic     sq_from_ar;
    logic     e_shift;
    logic     out_load;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic e_zero;
    logic e_lsb;
    logic m_zero;
    logic out_valid;
  } dp_sts_t;

endpackage

/* rtl/mau_datapath.sv */
// Datapath: operand registers, shared bit-serial reduce and multiply unit, and output register.
module mau_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  mau_pkg::dp_cmd_t          cmd,
  output mau_pkg::dp_sts_t          sts,
  input  logic                      modulus_we,
  input  logic [mau_pkg::DATA_W-1:0] modulus,
  input  logic [mau_pkg::DATA_W-1:0] operand_a,
  input  logic [mau_pkg::EXP_W-1:0]  operand_b,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [mau_pkg::DATA_W-1:0] residue
);
  import mau_pkg::*;

  logic [DATA_W-1:0] m_reg;
  logic [DATA_W-1:0] a_in;
  logic [EXP_W-1:0]  b_in;
  logic [DATA_W-1:0] ar;
  logic [DATA_W-1:0] sq;
  logic [DATA_W-1:0] acc;
  logic [EXP_W-1:0]  e;
  logic              busy;
  usel_t             dsel;
  logic [DATA_W-1:0] w;
  logic [DATA_W-1:0] x;
  logic [EXP_W-1:0]  y;
  logic [CNT_W-1:0]  cnt;

  logic [EXP_W-1:0]  m_ext;
  logic              ybit;
  logic [EXP_W-1:0]  red_t;
  logic [EXP_W-1:0]  red_n;
  logic [EXP_W-1:0]  dbl;
  logic [EXP_W-1:0]  dbl_r;
  logic [EXP_W-1:0]  sum;
  logic [EXP_W-1:0]  sum_r;
  logic [DATA_W-1:0] step_val;
  logic              is_red;
  logic [EXP_W-1:0]  add_s;
  logic [EXP_W-1:0]  add_r;
  logic [EXP_W-1:0]  sub_s;
  logic [EXP_W-1:0]  sub_r;
  logic [EXP_W-1:0]  fermat;

  assign m_ext = {1'b0, m_reg};
  assign ybit = y[cnt];
  assign is_red = (dsel == US_RED_A) || (dsel == US_RED_B);

  always_comb begin
    red_t = {w, ybit};
    red_n = (red_t >= m_ext) ? red_t - m_ext : red_t;
    dbl = {w, 1'b0};
    dbl_r = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum = dbl_r + (ybit ? {1'b0, x} : {EXP_W{1'b0}});
    sum_r = (sum >= m_ext) ? sum - m_ext : sum;
    step_val = is_red ? red_n[DATA_W-1:0] : sum_r[DATA_W-1:0];
    add_s = {1'b0, ar} + {1'b0, sq};
    add_r = (add_s >= m_ext) ? add_s - m_ext : add_s;
    sub_s = {1'b0, ar} + m_ext - {1'b0, sq};
    sub_r = (sub_s >= m_ext) ? sub_s - m_ext : sub_s;
    fermat = (m_reg >= 31'd2) ? m_ext - 32'd2 : {EXP_W{1'b0}};
  end

  assign sts.unit_done = busy && (cnt == '0);
  assign sts.e_zero = (e == '0);
  assign sts.e_lsb = e[0];
  assign sts.m_zero = (m_reg == '0);
  assign sts.out_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_reg <= MOD_RESET;
    end else if (modulus_we) begin
      m_reg <= modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.unit_start) begin
      busy <= 1'b1;
    end else if (busy && (cnt == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_in <= operand_a;
      b_in <= operand_b;
    end
    if (cmd.unit_start) begin
      dsel <= cmd.unit_sel;
      w <= '0;
      cnt <= CNT_W'(EXP_W - 1);
      case (cmd.unit_sel)
        US_RED_A: begin
          x <= '0;
          y <= {1'b0, a_in};
        end
        US_RED_B: begin
          x <= '0;
          y <= b_in;
        end
        US_ACC_SQ: begin
          x <= acc;
          y <= {1'b0, sq};
        end
        US_SQ_SQ: begin
          x <= sq;
          y <= {1'b0, sq};
        end
        US_AR_SQ: begin
          x <= ar;
          y <= {1'b0, sq};
        end
        US_AR_ACC: begin
          x <= ar;
          y <= {1'b0, acc};
        end
        default: begin
          x <= '0;
          y <= '0;
        end
      endcase
    end else if (busy) begin
      w <= step_val;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        case (dsel)
          US_RED_A: ar <= step_val;
          US_RED_B: sq <= step_val;
          US_SQ_SQ: sq <= step_val;
          default: acc <= step_val;
        endcase
      end
    end
    if (cmd.pow_init) begin
      acc <= 31'd1;
      e <= cmd.e_fermat ? fermat : (b_in & EXP_MASK);
      if (cmd.sq_from_ar) begin
        sq <= ar;
      end
    end
    if (cmd.e_shift) begin
      e <= e >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_sel)
        RS_ACC: residue <= acc;
        RS_ADD: residue <= add_r[DATA_W-1:0];
        RS_SUB: residue <= sub_r[DATA_W-1:0];
        default: residue <= '0;
      endcase
    end
  end

endmodule

/* rtl/mau_ctrl.sv */
// Controller state machine that sequences reductions, the exponent loop and the result load.
module mau_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       operation,
  input  logic             out_stall,
  input  mau_pkg::dp_sts_t sts,
  output mau_pkg::dp_cmd_t cmd
);
  import mau_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_RED_A     = 9'b000000010,
    S_RED_B     = 9'b000000100,
    S_POW_INIT  = 9'b000001000,
    S_POW_CHK   = 9'b000010000,
    S_POW_MUL   = 9'b000100000,
    S_POW_SQR   = 9'b001000000,
    S_FINAL_MUL = 9'b010000000,
    S_FINISH    = 9'b100000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] op;
  logic       bad;
  logic       launched;
  logic       accept;
  logic       in_unit;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && (state == S_IDLE);
  assign in_unit = (state == S_RED_A) || (state == S_RED_B) || (state == S_POW_MUL) ||
                   (state == S_POW_SQR) || (state == S_FINAL_MUL);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.load_in = accept;
    cmd.unit_start = in_unit && !launched;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.m_zero || (operation > OP_INV)) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_RED_A;
          end
        end
      end
      S_RED_A: begin
        cmd.unit_sel = US_RED_A;
        if (sts.unit_done) begin
          if ((op == OP_POWER) || (op == OP_INV)) begin
            state_next = S_POW_INIT;
          end else begin
            state_next = S_RED_B;
          end
        end
      end
      S_RED_B: begin
        cmd.unit_sel = US_RED_B;
        if (sts.unit_done) begin
          if (op == OP_MUL) begin
            state_next = S_FINAL_MUL;
          end else if (op == OP_DIV) begin
            state_next = S_POW_INIT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_POW_INIT: begin
        cmd.pow_init = 1'b1;
        cmd.e_fermat = (op != OP_POWER);
        cmd.sq_from_ar = (op != OP_DIV);
        state_next = S_POW_CHK;
      end
      S_POW_CHK: begin
        if (sts.e_zero) begin
          state_next = (op == OP_DIV) ? S_FINAL_MUL : S_FINISH;
        end else if (sts.e_lsb) begin
          state_next = S_POW_MUL;
        end else begin
          state_next = S_POW_SQR;
        end
      end
      S_POW_MUL: begin
        cmd.unit_sel = US_ACC_SQ;
        if (sts.unit_done) begin
          state_next = S_POW_SQR;
        end
      end
      S_POW_SQR: begin
        cmd.unit_sel = US_SQ_SQ;
        if (sts.unit_done) begin
          cmd.e_shift = 1'b1;
          state_next = S_POW_CHK;
        end
      end
      S_FINAL_MUL: begin
        cmd.unit_sel = (op == OP_DIV) ? US_AR_ACC : US_AR_SQ;
        if (sts.unit_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (bad) begin
          cmd.res_sel = RS_ZERO;
        end else if (op == OP_ADD) begin
          cmd.res_sel = RS_ADD;
        end else if (op == OP_SUB) begin
          cmd.res_sel = RS_SUB;
        end else begin
          cmd.res_sel = RS_ACC;
        end
        if (!sts.out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (sts.unit_done) begin
        launched <= 1'b0;
      end else if (cmd.unit_start) begin
        launched <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= operation;
      bad <= sts.m_zero || (operation > OP_INV);
    end
  end

endmodule

/* rtl/modular_arithmetic_unit.sv */
// Top level of the modular arithmetic unit: controller and datapath.
//
// One request on the input channel carries an operation code and two operands; it is taken
// at a clock edge where in_valid is high and in_stall is low. Exactly one residue comes back
// on the output channel, taken where out_valid is high and out_stall is low.
// The user must write the modulus register through modulus_we and modulus only while no
// request is open; the block does not enforce this. The block holds one request at a time.
// Every reduction and modular multiply runs on one shared bit-serial unit. Add and subtract
// reduce both operands, multiply adds one modular multiply. Power, inverse and divide run one
// square for each exponent bit and one more multiply for each set bit.
// A finished residue waits in the output register while the next request is accepted; the
// controller stalls before loading a new residue while the receiver still stalls the old.
// Synchronous reset returns the controller to idle, drops out_valid and sets the modulus to
// 1000000007.
module modular_arithmetic_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       modulus_we,
  input  logic [mau_pkg::DATA_W-1:0] modulus,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 operation,
  input  logic [mau_pkg::DATA_W-1:0] operand_a,
  input  logic [mau_pkg::EXP_W-1:0]  operand_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mau_pkg::DATA_W-1:0] residue
);
  import mau_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mau_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .modulus_we (modulus_we),
    .modulus    (modulus),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .residue    (residue)
  );

endmodule

/* rtl/mau_checker.sv */
// Port-level assertions for the modular arithmetic unit and the bind that attaches them.
module mau_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [mau_pkg::DATA_W-1:0] residue
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(residue))
    else $error("Stalled result changed or dropped.");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input not stalled while a request is in progress.");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("Result appeared in the cycle right after the request.");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .residue   (residue)
);

/* tb/tb.sv */
// Self-checking testbench for the modular arithmetic unit: directed table, then random requests.
`timescale 1ns / 100ps

module tb;
  import mau_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] mod_val;
    logic [2:0]        op;
    logic [DATA_W-1:0] a;
    logic [EXP_W-1:0]  b;
    bit                known;
    logic [DATA_W-1:0] res;
  } vec_t;

  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam logic [DATA_W-1:0] MAX_A = {DATA_W{1'b1}};
  localparam logic [EXP_W-1:0] MAX_B = {EXP_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic modulus_we = 1'b0;
  logic [DATA_W-1:0] modulus = MOD_RESET;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] operation = OP_ADD;
  logic [DATA_W-1:0] operand_a = '0;
  logic [EXP_W-1:0] operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] residue;

  logic [DATA_W-1:0] cur_mod = MOD_RESET;
  logic [DATA_W-1:0] residue_q[$];
  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;

  always #4 clk = ~clk;

  modular_arithmetic_unit u_dut (
    .clk(clk), .rst(rst), .modulus_we(modulus_we), .modulus(modulus),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
    .out_stall(out_stall), .residue(residue)
  );

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq = base % m;
    while (e != 64'd0) begin
      if (e[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [DATA_W-1:0] predict_residue(logic [2:0] op, logic [DATA_W-1:0] a,
                                                        logic [EXP_W-1:0] b,
                                                        logic [DATA_W-1:0] m_in);
    logic [63:0] m;
    logic [63:0] ar;
    logic [63:0] br;
    logic [63:0] fe;
    logic [63:0] r;
    m = 64'(m_in);
    r = '0;
    if (m != 64'd0) begin
      ar = 64'(a) % m;
      br = 64'(b) % m;
      fe = (m >= 64'd2) ? m - 64'd2 : 64'd0;
      case (op)
        OP_POWER: r = pow_mod(64'(a), 64'(b & EXP_MASK), m);
        OP_ADD:   r = (ar + br) % m;
        OP_SUB:   r = (ar + m - br) % m;
        OP_MUL:   r = (ar * br) % m;
        OP_DIV:   r = (ar * (pow_mod(64'(b), fe, m) % m)) % m;
        OP_INV:   r = pow_mod(64'(a), fe, m);
        default:  r = '0;
      endcase
    end
    return r[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
    if (!rst && out_valid && !out_stall) begin
      if (residue_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected residue %0d", residue);
      end else begin
        if (residue !== residue_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("Residue mismatch: expected %0d, got %0d", residue_q[0], residue);
        end
        void'(residue_q.pop_front());
      end
    end
  end

  task automatic set_modulus(logic [DATA_W-1:0] v);
    in_valid <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    modulus_we <= 1'b1;
    modulus <= v;
    @(posedge clk);
    modulus_we <= 1'b0;
    cur_mod = v;
  endtask

  task automatic send_request(logic [2:0] op, logic [DATA_W-1:0] a, logic [EXP_W-1:0] b,
                              bit known, logic [DATA_W-1:0] res);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (in_stall);
    residue_q = {residue_q, (known ? res : predict_residue(op, a, b, cur_mod))};
  endtask

  function automatic logic [DATA_W-1:0] rand_a();
    case ($urandom_range(3))
      0: return DATA_W'($urandom_range(20));
      1: return MAX_A - DATA_W'($urandom_range(3));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    vec_t dir[$];
    logic [DATA_W-1:0] mods[8];
    logic [2:0] op;
    logic [EXP_W-1:0] b;
    dir = '{
      '{MOD_RESET, OP_POWER, 31'd2, 32'd0, 1'b1, 31'd1},
      '{MOD_RESET, OP_POWER, 31'd2, 32'd10, 1'b1, 31'd1024},
      '{MOD_RESET, OP_POWER, MAX_A, MAX_B, 1'b0, 31'd0},
      '{MOD_RESET, OP_ADD, MAX_A, MAX_B, 1'b0, 31'd0},
      '{MOD_RESET, OP_SUB, 31'd0, 32'd1, 1'b1, 31'd1000000006},
      '{MOD_RESET, OP_MUL, MAX_A, MAX_B, 1'b0, 31'd0},
      '{MOD_RESET, OP_DIV, 31'd10, 32'd5, 1'b1, 31'd2},
      '{MOD_RESET, OP_DIV, 31'd7, 32'd0, 1'b1, 31'd0},
      '{MOD_RESET, OP_INV, 31'd0, 32'd0, 1'b1, 31'd0},
      '{MOD_RESET, OP_INV, 31'd1, MAX_B, 1'b1, 31'd1},
      '{MOD_RESET, OP_INV, 31'd12345, 32'd0, 1'b0, 31'd0},
      '{MOD_RESET, OP_BAD6, MAX_A, MAX_B, 1'b1, 31'd0},
      '{MOD_RESET, OP_BAD7, 31'd5, 32'd5, 1'b1, 31'd0},
      '{31'd1, OP_POWER, 31'd5, 32'd0, 1'b1, 31'd1},
      '{31'd1, OP_POWER, 31'd5, 32'd3, 1'b1, 31'd0},
      '{31'd1, OP_INV, 31'd5, 32'd0, 1'b1, 31'd1},
      '{31'd1, OP_DIV, 31'd5, 32'd3, 1'b1, 31'd0},
      '{31'd2, OP_INV, 31'd0, 32'd0, 1'b1, 31'd1},
      '{31'd2, OP_DIV, 31'd3, 32'd0, 1'b1, 31'd1},
      '{31'd0, OP_POWER, 31'd3, 32'd0, 1'b1, 31'd0},
      '{31'd0, OP_ADD, MAX_A, MAX_B, 1'b1, 31'd0},
      '{31'd0, OP_INV, 31'd3, 32'd0, 1'b1, 31'd0},
      '{MAX_A, OP_SUB, 31'd0, MAX_B, 1'b0, 31'd0},
      '{MAX_A, OP_INV, 31'd2, 32'd0, 1'b0, 31'd0},
      '{MAX_A, OP_DIV, MAX_A, 32'd3, 1'b0, 31'd0}
    };
    mods = '{MAX_A, 31'd97, 31'd1000, 31'd3, 31'd1, 31'd0, 31'd65537, 31'd0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir[i]) begin
      if (dir[i].mod_val != cur_mod) set_modulus(dir[i].mod_val);
      send_request(dir[i].op, dir[i].a, dir[i].b, dir[i].known, dir[i].res);
    end
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle = 7;
        recv_idle = 69;
      end else if (p < 6) begin
        send_idle = 69;
        recv_idle = 7;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_modulus(p == 8 ? DATA_W'($urandom_range(32'h7fffffff, 1)) :
                  (p == 7 ? MOD_RESET : mods[p]));
      for (int n = 0; n < 30; n++) begin
        op = 3'($urandom_range(7));
        b = ($urandom_range(3) == 0) ? EXP_W'($urandom_range(40)) : EXP_W'($urandom);
        if ($urandom_range(9) == 0) b = MAX_B;
        send_request(op, rand_a(), b, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* modular_arithmetic_unit.f */
rtl/mau_pkg.sv
rtl/mau_datapath.sv
rtl/mau_ctrl.sv
rtl/modular_arithmetic_unit.sv
rtl/mau_checker.sv
tb/tb.sv
